// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/brle_pkg.sv
// ---------------------------------------------------------------------------
// brle_pkg
// Shared types, codes and the run-code planning function.
// ---------------------------------------------------------------------------
package brle_pkg;

	localparam logic       CMD_ADD   = 1'b0;
	localparam logic       CMD_FLUSH = 1'b1;

	localparam logic [1:0] STAT_DATA = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_OVFL = 2'd2;

	localparam logic [1:0] WIDTH_BYTE = 2'd0;
	localparam logic [1:0] WIDTH_HALF = 2'd1;

	localparam logic       REG_MIN_WIDTH   = 1'b0;
	localparam logic       REG_START_LEVEL = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] min_width;
		logic       start_level;
	} cfg_t;

	// One queued job: a run code or a rejection status.
	typedef struct packed {
		logic [31:0] total;
		logic [1:0]  status;
		logic [1:0]  pre;     // leading 0xff escape bytes
		logic [2:0]  nbytes;  // total bytes incl. escapes, 1..7
	} job_t;

	function automatic job_t plan_run(logic [31:0] total, logic [1:0] wcode);
		job_t j;
		j.total  = total;
		j.status = STAT_DATA;
		j.pre    = 2'd0;
		j.nbytes = 3'd4;
		case (wcode)
			WIDTH_BYTE: begin
				if (total < 32'h0000_00ff) begin
					j.nbytes = 3'd1;
				end else if (total < 32'h0000_ffff) begin
					j.pre    = 2'd1;
					j.nbytes = 3'd3;
				end else begin
					j.pre    = 2'd3;
					j.nbytes = 3'd7;
				end
			end
			WIDTH_HALF: begin
				if (total < 32'h0000_ffff) begin
					j.nbytes = 3'd2;
				end else begin
					j.pre    = 2'd2;
					j.nbytes = 3'd6;
				end
			end
			default: begin
				j.nbytes = 3'd4;
			end
		endcase
		return j;
	endfunction

	function automatic job_t reject(logic [1:0] status);
		job_t j;
		j.total  = '0;
		j.status = status;
		j.pre    = 2'd0;
		j.nbytes = 3'd1;
		return j;
	endfunction

endpackage

// File: sv/brle_if.sv
// ---------------------------------------------------------------------------
// brle channel interfaces
// Valid/ready channels for run items and for coded stream bytes.
// ---------------------------------------------------------------------------
interface brle_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        level;
	logic [31:0] run_count;

	modport source (output valid, cmd, level, run_count, input ready);
	modport sink (input valid, cmd, level, run_count, output ready);
endinterface

interface brle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, out_byte, status, last, input ready);
	modport sink (input valid, out_byte, status, last, output ready);
endinterface

// File: sv/brle_front.sv
// ---------------------------------------------------------------------------
// brle_front
// Accepts run items, keeps the pending run and queues run codes or rejects.
// ---------------------------------------------------------------------------
module brle_front (
	input  logic               clk,
	input  logic               arst_n,
	brle_in_if.sink            runs,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_data,
	input  logic               q_full,
	output logic               push,
	output brle_pkg::job_t     push_job
);
	import brle_pkg::*;

	cfg_t        cfg_q;
	logic        run_level_q;
	logic [31:0] run_total_q;
	logic        accept;
	logic        ovfl;

	assign runs.ready = !q_full;
	assign accept     = runs.valid && runs.ready;
	// count >= 0xffffffff - total
	assign ovfl       = runs.run_count >= ~run_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_WIDTH:   cfg_q.min_width   <= cfg_data;
				REG_START_LEVEL: cfg_q.start_level <= cfg_data[0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		push     = 1'b0;
		push_job = plan_run(run_total_q, cfg_q.min_width);
		if (accept) begin
			if (runs.cmd == CMD_FLUSH) begin
				push = 1'b1;
			end else if (runs.run_count == '0) begin
				push     = 1'b1;
				push_job = reject(STAT_ZERO);
			end else if (runs.level == run_level_q) begin
				if (ovfl) begin
					push     = 1'b1;
					push_job = reject(STAT_OVFL);
				end
			end else begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_level_q <= 1'b0;
			run_total_q <= '0;
		end else if (accept) begin
			if (runs.cmd == CMD_FLUSH) begin
				run_level_q <= cfg_q.start_level;
				run_total_q <= '0;
			end else if (runs.run_count != '0) begin
				if (runs.level != run_level_q) begin
					run_level_q <= runs.level;
					run_total_q <= runs.run_count;
				end else if (!ovfl) begin
					run_total_q <= run_total_q + runs.run_count;
				end
			end
		end
	end

endmodule

// File: sv/brle_fifo.sv
// ---------------------------------------------------------------------------
// brle_fifo
// Short job queue between the front and the byte emitter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brle_fifo #(
	parameter int Depth = brle_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brle_pkg::job_t push_job,
	input  logic           pop,
	output brle_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import brle_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	job_t          entries_q [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
		return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full  = count_q == CW'(Depth);
	assign empty = count_q == '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_IMPL(a_no_overrun, clk, arst_n, push, !full, "push into full queue")
	`ASSERT_IMPL(a_no_underrun, clk, arst_n, pop, !empty, "pop from empty queue")
	`ASSERT_PROP(a_count_range, clk, arst_n, count_q <= CW'(Depth), "queue count out of range")

endmodule

// File: sv/brle_back.sv
// ---------------------------------------------------------------------------
// brle_back
// Expands queued jobs into stream words, one byte per cycle unless the stream stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  brle_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	brle_out_if.source     stream
);
	import brle_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       adv;
	logic       at_last;
	logic [2:0] sel;
	logic [7:0] cur_byte;

	assign adv     = busy_q && (!valid_q || stream.ready);
	assign at_last = idx_q == (job_q.nbytes - 3'd1);
	assign pop     = !empty && (!busy_q || (adv && at_last));

	// escapes first, then the total little-endian
	assign sel      = idx_q - {1'b0, job_q.pre};
	assign cur_byte = (idx_q < {1'b0, job_q.pre}) ? 8'hff : job_q.total[sel[1:0]*8 +: 8];

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (adv) begin
			byte_q   <= cur_byte;
			status_q <= job_q.status;
			last_q   <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 3'd1;
			end
			if (adv) begin
				valid_q <= 1'b1;
			end else if (stream.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign stream.valid    = valid_q;
	assign stream.out_byte = byte_q;
	assign stream.status   = status_q;
	assign stream.last     = last_q;

	`ASSERT_IMPL(a_idx_in_job, clk, arst_n, busy_q, idx_q < job_q.nbytes, "byte index past job")
	`ASSERT_IMPL(a_reject_single, clk, arst_n, busy_q && job_q.status != STAT_DATA, job_q.nbytes == 3'd1 && job_q.total == '0, "reject job not single zero word")
	`ASSERT_IMPL(a_reject_last, clk, arst_n, valid_q && status_q != STAT_DATA, last_q && byte_q == 8'h00, "reject word not last")

endmodule

// File: sv/binary_run_length_encoder_core.sv
// ---------------------------------------------------------------------------
// binary_run_length_encoder_core
// Run-length coder for a one-bit level signal, escape-extended lengths.
// ---------------------------------------------------------------------------
// An input word is accepted every cycle while the job queue (QueueDepth
// entries) has room; an add at the pending level gives no output unless its
// total would overflow. A level change or flush queues a run code that the
// emitter sends one byte per cycle unless the stream stalls, 1 to 7 bytes
// depending on the total and the minimum width, so sustained rate is set
// by the emitter's byte output. Rejects (zero count, total overflow) are
// one word each. There is no clearing pass after reset.
module binary_run_length_encoder_core #(
	parameter int QueueDepth = brle_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	brle_in_if.sink    runs,
	brle_out_if.source stream,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);
	import brle_pkg::*;

	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic q_full;
	logic q_empty;

	brle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.runs     (runs),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	brle_fifo #(
		.Depth(QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	brle_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (q_empty),
		.pop   (pop),
		.stream(stream)
	);

endmodule

// File: test/brle_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// brle_checker
// Watches the run and stream channels and the register port, predicts the
// coded byte stream of every accepted run word and compares each stream
// word, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module brle_checker (
	input  logic       clk,
	input  logic       arst_n,
	brle_in_if         runs,
	brle_out_if        stream,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	output int         fail_count,
	output int         expected_left
);
	import brle_pkg::*;

	localparam logic [31:0] ESC_BYTE = 32'h0000_00ff;
	localparam logic [31:0] ESC_HALF = 32'h0000_ffff;
	localparam logic [31:0] ESC_FULL = 32'hffff_ffff;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} stream_word_t;

	stream_word_t expected_words[$];
	stream_word_t code_words[$];

	logic [1:0]  min_width;
	logic        start_level;
	logic        run_level;
	logic [31:0] run_total;
	int          errors = 0;
	int          words_seen = 0;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: stream word %0d: %s", $time, words_seen, msg);
	endtask

	task automatic add_word(input logic [7:0] b, input logic [1:0] st);
		stream_word_t w;
		w.out_byte = b;
		w.status   = st;
		w.last     = 1'b0;
		code_words.push_back(w);
	endtask

	task automatic add_le(input logic [31:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			add_word(v[8*i +: 8], STAT_DATA);
	endtask

	// escape-extended length code, starting at the configured width
	task automatic code_run(input logic [31:0] total);
		logic [1:0] w;
		w = min_width;
		if (w == WIDTH_BYTE) begin
			if (total < ESC_BYTE) begin
				add_le(total, 1);
				return;
			end
			add_le(ESC_BYTE, 1);
			w = WIDTH_HALF;
		end
		if (w == WIDTH_HALF) begin
			if (total < ESC_HALF) begin
				add_le(total, 2);
				return;
			end
			add_le(ESC_HALF, 2);
		end
		add_le(total, 4);
	endtask

	task automatic predict_run_word(input logic cmd, input logic level, input logic [31:0] count);
		stream_word_t w;
		if (cmd == CMD_FLUSH) begin
			code_run(run_total);
			run_level = start_level;
			run_total = '0;
		end else if (count == 32'd0) begin
			add_word(8'h00, STAT_ZERO);
		end else if (level == run_level) begin
			if (count >= ESC_FULL - run_total)
				add_word(8'h00, STAT_OVFL);
			else
				run_total = run_total + count;
		end else begin
			code_run(run_total);
			run_level = level;
			run_total = count;
		end
		if (code_words.size() != 0) begin
			w = code_words.pop_back();
			w.last = 1'b1;
			code_words.push_back(w);
			foreach (code_words[i])
				expected_words.push_back(code_words[i]);
			code_words.delete();
		end
	endtask

	task automatic check_stream_word(input logic [7:0] b, input logic [1:0] st, input logic lst);
		stream_word_t want;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word byte 0x%0h status %0d", b, st));
		end else begin
			want = expected_words.pop_front();
			if (b !== want.out_byte)
				report_mismatch($sformatf("out_byte 0x%0h, expected 0x%0h", b, want.out_byte));
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (lst !== want.last)
				report_mismatch($sformatf("last %0b, expected %0b", lst, want.last));
		end
		words_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width   = WIDTH_BYTE;
			start_level = 1'b0;
			run_level   = 1'b0;
			run_total   = '0;
			expected_words.delete();
			code_words.delete();
			expected_left <= 0;
			fail_count    <= errors;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MIN_WIDTH)
					min_width = cfg_data;
				else
					start_level = cfg_data[0];
			end
			if (runs.valid && runs.ready)
				predict_run_word(runs.cmd, runs.level, runs.run_count);
			if (stream.valid && stream.ready)
				check_stream_word(stream.out_byte, stream.status, stream.last);
			expected_left <= expected_words.size();
			fail_count    <= errors;
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives run words and register writes into the run-length coder with
// random gaps and output stalls; the checker beside the block predicts and
// compares the byte stream.
// ---------------------------------------------------------------------------
module tb;
	import brle_pkg::*;

	localparam logic [1:0] WIDTH_WORD  = 2'd2;
	localparam logic [1:0] WIDTH_SPARE = 2'd3;  // decodes as four bytes
	localparam int PHASE_WORDS   = 78;
	localparam int SETTLE_CYCLES = 16;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [1:0] cfg_data;
	int         fail_count;
	int         expected_left;
	logic       last_level;
	logic       start_now;
	int         burst_left;

	brle_in_if  runs_if ();
	brle_out_if stream_if ();

	binary_run_length_encoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.runs     (runs_if),
		.stream   (stream_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	brle_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.runs         (runs_if),
		.stream       (stream_if),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.expected_left(expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end

	// stream back-pressure: short stalls, a few long ones, calm stretches
	initial begin : stream_stall
		int stall_left;
		int calm_left;
		int r;
		stall_left = 0;
		calm_left  = 0;
		stream_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stream_if.ready <= 1'b0;
				stall_left--;
			end else begin
				stream_if.ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 2)
						calm_left = $urandom_range(40, 200);
					else if (r < 22)
						stall_left = $urandom_range(1, 3);
					else if (r < 25)
						stall_left = $urandom_range(10, 50);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly short runs, with totals steered at the escape boundaries
	function automatic logic [31:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom_range(1, 20);
		if (r < 60)
			return $urandom_range(21, 300);
		if (r < 70)
			return $urandom_range(32'h0f0, 32'h110);
		if (r < 78)
			return $urandom_range(32'h0000_fff0, 32'h0001_0010);
		if (r < 86)
			return $urandom;
		if (r < 89)
			return 32'hffff_ffff - $urandom_range(0, 20);
		if (r < 93)
			return 32'd0;
		return $urandom_range(1, 32'h000f_ffff);
	endfunction

	task automatic send_run_word(input logic cmd, input logic level, input logic [31:0] count);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			runs_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		runs_if.valid     <= 1'b1;
		runs_if.cmd       <= cmd;
		runs_if.level     <= level;
		runs_if.run_count <= count;
		do @(posedge clk); while (!runs_if.ready);
	endtask

	task automatic add_samples(input logic level, input logic [31:0] count);
		send_run_word(CMD_ADD, level, count);
		last_level = level;
	endtask

	// level and count are don't-care on a flush
	task automatic flush_run();
		send_run_word(CMD_FLUSH, 1'($urandom_range(0, 1)), $urandom);
		last_level = start_now;
	endtask

	task automatic wait_idle();
		runs_if.valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [1:0] width, input logic start);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_WIDTH;
		cfg_data  <= width;
		@(posedge clk);
		cfg_index <= REG_START_LEVEL;
		cfg_data  <= {1'b0, start};
		@(posedge clk);
		cfg_we    <= 1'b0;
		start_now = start;
	endtask

	task automatic run_random_phase(input int n, input bit hold_mid);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				flush_run();
			else
				add_samples((r < 72) ? ~last_level : last_level, pick_count());
			if (hold_mid && i == n / 2)
				wait_idle();
		end
	endtask

	initial begin
		runs_if.valid     <= 1'b0;
		runs_if.cmd       <= CMD_ADD;
		runs_if.level     <= 1'b0;
		runs_if.run_count <= '0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_MIN_WIDTH;
		cfg_data          <= WIDTH_BYTE;
		arst_n            <= 1'b0;
		last_level = 1'b0;
		start_now  = 1'b0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(WIDTH_BYTE, 1'b0);
		add_samples(1'b0, 32'd0);               // zero count reject
		flush_run();                            // empty run
		add_samples(1'b1, 32'd5);               // empty start run closed
		add_samples(1'b1, 32'hffff_fff9);
		add_samples(1'b1, 32'd1);               // total would hit all-ones
		add_samples(1'b0, 32'h0000_00fe);       // seven-byte code
		add_samples(1'b1, 32'h0000_00ff);
		add_samples(1'b0, 32'h0000_fffe);
		add_samples(1'b1, 32'h0000_ffff);
		add_samples(1'b0, 32'hffff_ffff);       // no overflow check on a change
		add_samples(1'b0, 32'd1);
		add_samples(1'b1, 32'h8000_0000);
		flush_run();
		flush_run();

		wait_idle();
		write_config(WIDTH_HALF, 1'b1);
		flush_run();
		add_samples(1'b1, 32'd3);
		add_samples(1'b1, 32'h0000_fffa);
		add_samples(1'b0, 32'd2);
		add_samples(1'b0, 32'hffff_fffc);
		add_samples(1'b1, 32'd7);

		wait_idle();
		write_config(WIDTH_SPARE, 1'b0);
		flush_run();

		run_random_phase(PHASE_WORDS, 1'b0);
		wait_idle();
		write_config(WIDTH_WORD, 1'b1);
		run_random_phase(PHASE_WORDS, 1'b1);
		wait_idle();
		write_config(WIDTH_BYTE, 1'b1);
		run_random_phase(PHASE_WORDS, 1'b0);
		wait_idle();
		write_config(WIDTH_HALF, 1'b0);
		run_random_phase(PHASE_WORDS, 1'b0);
		wait_idle();
		write_config(WIDTH_BYTE, 1'b0);
		run_random_phase(PHASE_WORDS, 1'b0);
		wait_idle();

		if (fail_count == 0 && expected_left == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
